FILE: hdl/priority_run_queue_table_macros.svh
// ----------------------------------------------------------------------------
// Priority run queue table assertion macros
// Shared assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_RUN_QUEUE_TABLE_MACROS_SVH
`define PRIORITY_RUN_QUEUE_TABLE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define PRQT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define PRQT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/prqt_pkg.sv
// ----------------------------------------------------------------------------
// Priority run queue table package
// Shared types, codes and constants of the process table.
// ----------------------------------------------------------------------------
package prqt_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_SETRUN = 2'd3
  } action_t;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [15:0] ID_RESERVED_A = 16'd1;
  localparam logic [15:0] ID_RESERVED_B = 16'd2;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic        runnable;
  } slot_t;

  typedef struct packed {
    logic        best_valid;
    logic [15:0] best_id;
    logic [7:0]  best_prio;
    logic        least_valid;
    logic [7:0]  least_prio;
  } min_result_t;

endpackage

FILE: hdl/prqt_min_unit.sv
// ----------------------------------------------------------------------------
// Priority run queue table minimum unit
// Compares one table entry per cycle, while feed is high, against the running best and least.
// ----------------------------------------------------------------------------
module prqt_min_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic                 feed,
  input  prqt_pkg::slot_t      slot,
  output prqt_pkg::min_result_t result
);
  import prqt_pkg::*;

  min_result_t acc;
  logic        take_best;
  logic        take_least;

  always_comb begin
    take_best  = slot.runnable && (!acc.best_valid || (slot.prio < acc.best_prio));
    take_least = (slot.id != ID_RESERVED_A) && (slot.id != ID_RESERVED_B) &&
                 (!acc.least_valid || (slot.prio < acc.least_prio));
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc <= '0;
    end else if (feed) begin
      if (take_best) begin
        acc.best_valid <= 1'b1;
        acc.best_id    <= slot.id;
        acc.best_prio  <= slot.prio;
      end
      if (take_least) begin
        acc.least_valid <= 1'b1;
        acc.least_prio  <= slot.prio;
      end
    end
  end

  assign result = acc;

endmodule

FILE: hdl/priority_run_queue_table.sv
// ----------------------------------------------------------------------------
// Priority run queue table
// Insertion-ordered process table with append, remove, look-up and
// set-runnable actions, reporting the best runnable entry after each one.
// ----------------------------------------------------------------------------
//  Channel | Handshake             | Fields
//  --------+-----------------------+--------------------------------------------
//  req     | req_valid, req_stall  | action, proc_id, prio_in, runnable_in
//  rsp     | rsp_valid, rsp_stall  | status, best_*, least_*, occupancy
//
// All table reads go through one memory read port, one entry per cycle.
// Append writes the new entry unless the table is full and then scans the
// table; look-up and set-runnable search for the match and then scan, and
// remove searches, shifts the later entries down one place and then scans.
// A finished result waits in the output register while a new transaction is
// taken; a stalled output delays only the finish of that next transaction.
// Reset empties the table at once; no clearing pass is needed.
module priority_run_queue_table #(
  parameter int TABLE_DEPTH = prqt_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  action,
  input  logic [15:0] proc_id,
  input  logic [7:0]  prio_in,
  input  logic        runnable_in,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic        best_valid,
  output logic [15:0] best_id,
  output logic [7:0]  best_prio,
  output logic        least_valid,
  output logic [7:0]  least_prio,
  output logic [6:0]  occupancy
);
  import prqt_pkg::*;
  `include "priority_run_queue_table_macros.svh"

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FIND  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_SCAN  = 4'b1000
  } state_t;

  state_t      state;
  action_t     act;
  logic [15:0] key_id;
  logic        key_run;
  logic [1:0]  result_status;
  logic [CW-1:0] fill;
  logic [CW-1:0] idx;
  logic          pend;
  logic [AW-1:0] pend_idx;

  slot_t mem [TABLE_DEPTH];
  slot_t rd_data;
  slot_t wr_data;
  logic  [AW-1:0] wr_addr;
  logic  wr_en;

  logic req_take;
  logic full;
  logic issue;
  logic hit;
  logic scan_done;
  logic load;
  min_result_t min_res;

  always_comb begin
    req_take  = req_valid && !req_stall;
    full      = (fill == CW'(TABLE_DEPTH));
    issue     = (state inside {S_FIND, S_SHIFT, S_SCAN}) && (idx < fill);
    hit       = (state == S_FIND) && pend && (rd_data.id == key_id);
    scan_done = (state == S_SCAN) && !issue && !pend;
    load      = scan_done && !(rsp_valid && rsp_stall);

    wr_en   = 1'b0;
    wr_addr = fill[AW-1:0];
    wr_data = '{id: proc_id, prio: prio_in, runnable: runnable_in};
    if (req_take && (action_t'(action) == ACT_APPEND) && !full) begin
      wr_en = 1'b1;
    end else if (hit && (act == ACT_SETRUN)) begin
      wr_en   = 1'b1;
      wr_addr = pend_idx;
      wr_data = '{id: rd_data.id, prio: rd_data.prio, runnable: key_run};
    end else if ((state == S_SHIFT) && pend) begin
      wr_en   = 1'b1;
      wr_addr = pend_idx - AW'(1);
      wr_data = rd_data;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      pend      <= 1'b0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (req_take) begin
            act           <= action_t'(action);
            key_id        <= proc_id;
            key_run       <= runnable_in;
            idx           <= '0;
            result_status <= ST_DONE;
            if (action_t'(action) == ACT_APPEND) begin
              if (full) begin
                result_status <= ST_FULL;
              end else begin
                fill <= fill + CW'(1);
              end
              state <= S_SCAN;
            end else begin
              state <= S_FIND;
            end
          end
        end
        S_FIND: begin
          if (hit) begin
            pend <= 1'b0;
            if (act == ACT_REMOVE) begin
              idx   <= CW'(pend_idx) + CW'(1);
              state <= S_SHIFT;
            end else begin
              idx   <= '0;
              state <= S_SCAN;
            end
          end else if (!issue && !pend) begin
            result_status <= ST_NOT_FOUND;
            idx           <= '0;
            state         <= S_SCAN;
          end else begin
            pend <= issue;
            if (issue) begin
              idx      <= idx + CW'(1);
              pend_idx <= idx[AW-1:0];
            end
          end
        end
        S_SHIFT: begin
          if (!issue && !pend) begin
            fill  <= fill - CW'(1);
            idx   <= '0;
            state <= S_SCAN;
          end else begin
            pend <= issue;
            if (issue) begin
              idx      <= idx + CW'(1);
              pend_idx <= idx[AW-1:0];
            end
          end
        end
        S_SCAN: begin
          if (load) begin
            state <= S_IDLE;
          end else begin
            pend <= issue;
            if (issue) begin
              idx      <= idx + CW'(1);
              pend_idx <= idx[AW-1:0];
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  prqt_min_unit u_min (
    .clk    (clk),
    .rst    (rst),
    .clear  (req_take),
    .feed   ((state == S_SCAN) && pend),
    .slot   (rd_data),
    .result (min_res)
  );

  always_ff @(posedge clk) begin
    if (load) begin
      status      <= result_status;
      best_valid  <= min_res.best_valid;
      best_id     <= min_res.best_id;
      best_prio   <= min_res.best_prio;
      least_valid <= min_res.least_valid;
      least_prio  <= min_res.least_prio;
      occupancy   <= 7'(fill);
    end
  end

  `PRQT_ASSERT_IMP(a_fill_bound, 1'b1, fill <= CW'(TABLE_DEPTH), "Fill count exceeds table depth.")
  `PRQT_ASSERT_NEXT(a_busy_after_take, req_take, state != S_IDLE, "Idle right after a transaction.")
  `PRQT_ASSERT_IMP(a_hit_in_range, hit, CW'(pend_idx) < fill, "Match found beyond the fill count.")
  `PRQT_ASSERT_IMP(a_shift_nonempty, state == S_SHIFT, fill != '0, "Remove shift on an empty table.")

endmodule
